@@ rtl/core/sle_pkg.sv @@
// Shared types and codes for the sequential list engine.
package sle_pkg;

	// Field widths of the request and result transactions.
	localparam int unsigned OP_W    = 3;
	localparam int unsigned POS_W   = 7;
	localparam int unsigned VAL_W   = 32;
	localparam int unsigned STAT_W  = 2;

	// Request opcodes.
	typedef enum logic [OP_W-1:0] {
		OP_READ   = 3'd0,
		OP_FIND   = 3'd1,
		OP_APPEND = 3'd2,
		OP_INSERT = 3'd3,
		OP_DELETE = 3'd4
	} op_t;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_BADPOS   = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	// One result transaction as handed from the sequencer to the output stage.
	typedef struct packed {
		status_t            status;
		logic [VAL_W-1:0]   read_value;
		logic [POS_W-1:0]   found_position;
		logic [POS_W-1:0]   list_length;
	} result_t;

endpackage

@@ rtl/core/sequential_list_engine_top.sv @@
// Top level of the sequential list engine: stream ports, sequencer and result register.
//
//  Channel   Direction  tdata (low bit first)                        tuser
//  s_*       in         position[6:0], value[38:7]                   opcode[2:0]
//  m_*       out        read_value[31:0], found_position[38:32],     status[1:0]
//                       list_length[45:39]
//
// One request is worked at a time. Append and rejected requests skip the memory
// walk; read walks one entry, find the whole list, insert the entries from the top
// down to the position and delete the entries above the position, each walk going
// through the entry memory at one read and one write per cycle.
// Reset clears the length; entry contents are undefined until written.
// A finished result waits in the output register while the next request is taken.
module sequential_list_engine_top
	import sle_pkg::*;
#(
	parameter int unsigned CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // position[6:0], value[38:7], zero fill
	input  logic [2:0]  s_tuser,   // opcode[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // read_value[31:0], found_position[38:32],
	                               // list_length[45:39], zero fill
	output logic [1:0]  m_tuser    // status[1:0]
);

	logic    res_valid, res_ready;
	result_t res, out_q;
	logic    out_valid_q;

	sle_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.opcode    (s_tuser),
		.position  (s_tdata[6:0]),
		.value     (s_tdata[38:7]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// The output register takes a result when empty or being drained.
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {2'b00, out_q.list_length, out_q.found_position, out_q.read_value};

	// The sequencer never takes a request while it offers a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && res_valid))
		else $error("request taken while a result is pending");

	// The reported length never exceeds the capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(out_q.list_length) <= CAPACITY))
		else $error("list length above capacity");

	// A nonzero read value only comes with a successful status.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.read_value != '0) |-> (out_q.status == ST_OK))
		else $error("read value on a failed request");

	// A find that reports not found carries no position.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.status == ST_NOTFOUND) |-> (out_q.found_position == '0))
		else $error("position reported with not found");

endmodule

@@ rtl/core/sle_mem.sv @@
// Entry storage: one write port and one read port with registered read data.
module sle_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6,
	parameter int unsigned DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/sle_ctrl.sv @@
// Request sequencer: decodes a request, walks the entry memory and builds the result.
module sle_ctrl
	import sle_pkg::*;
#(
	parameter int unsigned CAPACITY = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	// Request side.
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [OP_W-1:0]   opcode,
	input  logic [POS_W-1:0]  position,
	input  logic [VAL_W-1:0]  value,
	// Result side.
	output logic              res_valid,
	input  logic              res_ready,
	output result_t           res
);

	localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW   = $clog2(CAPACITY + 1);
	localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

	state_t state_q, state_d;

	// Request context.
	logic [OP_W-1:0]  op_q;
	logic [VAL_W-1:0] val_q;
	logic [AW-1:0]    pidx_q;
	status_t          status_q;

	// Walk control and results.
	logic [AW-1:0]    ptr_q;
	logic [CW-1:0]    left_q;
	logic             v_s1;
	logic [AW-1:0]    idx_s1;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    found_q;
	logic [VAL_W-1:0] rd_q;

	// Memory port.
	logic             mem_we, mem_re;
	logic [AW-1:0]    mem_waddr, mem_raddr;
	logic [VAL_W-1:0] mem_wdata, mem_rdata;

	// Decode of an incoming request.
	logic [CMPW-1:0]  pos_w, cnt_w, pos_m1, ins_left, del_left;
	status_t          dec_status;
	logic [CW-1:0]    dec_left;
	logic [AW-1:0]    dec_ptr;
	logic             accept, finish;
	status_t          fin_status;

	sle_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW),
		.DW    (VAL_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign pos_w    = CMPW'(position);
	assign cnt_w    = CMPW'(count_q);
	assign pos_m1   = pos_w - CMPW'(1);
	assign ins_left = cnt_w - pos_w + CMPW'(1);
	assign del_left = cnt_w - pos_w;

	// Range checks and the length of the memory walk for each opcode.
	always_comb begin
		dec_status = ST_OK;
		dec_left   = '0;
		dec_ptr    = '0;
		case (opcode)
			OP_READ: begin
				if (pos_w == '0 || pos_w > cnt_w) begin
					dec_status = ST_BADPOS;
				end else begin
					dec_left = CW'(1);
					dec_ptr  = pos_m1[AW-1:0];
				end
			end
			OP_FIND: begin
				dec_left = count_q;
			end
			OP_APPEND: begin
				if (cnt_w >= CMPW'(CAPACITY)) begin
					dec_status = ST_FULL;
				end
			end
			OP_INSERT: begin
				if (cnt_w >= CMPW'(CAPACITY)) begin
					dec_status = ST_FULL;
				end else if (pos_w == '0 || pos_w > cnt_w + CMPW'(1)) begin
					dec_status = ST_BADPOS;
				end else begin
					// Walk downward from the top entry, moving each up one place.
					dec_left = ins_left[CW-1:0];
					dec_ptr  = cnt_w[AW-1:0] - AW'(1);
				end
			end
			OP_DELETE: begin
				if (pos_w == '0 || pos_w > cnt_w) begin
					dec_status = ST_BADPOS;
				end else begin
					// Walk upward from the entry above the hole, moving each down.
					dec_left = del_left[CW-1:0];
					dec_ptr  = pos_w[AW-1:0];
				end
			end
			default: begin
				dec_status = ST_BADPOS;
			end
		endcase
	end

	// Final status: a find with no match reports not found.
	always_comb begin
		fin_status = status_q;
		if (op_q == OP_FIND && found_q == '0) begin
			fin_status = ST_NOTFOUND;
		end
	end

	// Next state and handshake outputs.
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = (dec_left != '0) ? S_SCAN : S_FINISH;
				end
			end
			S_SCAN: begin
				if (left_q == '0) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign accept = req_valid && req_ready;
	assign finish = res_valid && res_ready;

	// Memory reads during the walk, writes for moves and the final store.
	always_comb begin
		mem_re    = (state_q == S_SCAN) && (left_q != '0);
		mem_raddr = ptr_q;
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = mem_rdata;
		if (state_q == S_SCAN && v_s1) begin
			if (op_q == OP_INSERT) begin
				mem_we    = 1'b1;
				mem_waddr = idx_s1 + AW'(1);
			end else if (op_q == OP_DELETE) begin
				mem_we    = 1'b1;
				mem_waddr = idx_s1 - AW'(1);
			end
		end else if (finish && status_q == ST_OK) begin
			if (op_q == OP_APPEND) begin
				mem_we    = 1'b1;
				mem_waddr = count_q[AW-1:0];
				mem_wdata = val_q;
			end else if (op_q == OP_INSERT) begin
				mem_we    = 1'b1;
				mem_waddr = pidx_q;
				mem_wdata = val_q;
			end
		end
	end

	assign res.status         = fin_status;
	assign res.read_value     = rd_q;
	assign res.found_position = POS_W'(found_q);
	assign res.list_length    = (status_q != ST_OK) ? POS_W'(count_q) :
		(op_q == OP_APPEND || op_q == OP_INSERT) ? POS_W'(count_q + CW'(1)) :
		(op_q == OP_DELETE) ? POS_W'(count_q - CW'(1)) : POS_W'(count_q);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: walk counter, read pipeline flag and list length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			v_s1    <= 1'b0;
			count_q <= '0;
		end else begin
			v_s1 <= mem_re;
			if (accept) begin
				left_q <= dec_left;
			end else if (mem_re) begin
				left_q <= left_q - CW'(1);
			end
			if (finish && status_q == ST_OK) begin
				if (op_q == OP_APPEND || op_q == OP_INSERT) begin
					count_q <= count_q + CW'(1);
				end else if (op_q == OP_DELETE) begin
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	// Request context and walk data path.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= opcode;
			val_q    <= value;
			pidx_q   <= pos_m1[AW-1:0];
			status_q <= dec_status;
			ptr_q    <= dec_ptr;
			found_q  <= '0;
			rd_q     <= '0;
		end else begin
			if (mem_re) begin
				ptr_q <= (op_q == OP_INSERT) ? ptr_q - AW'(1) : ptr_q + AW'(1);
			end
			if (state_q == S_SCAN && v_s1) begin
				if (op_q == OP_READ) begin
					rd_q <= mem_rdata;
				end else if (op_q == OP_FIND && mem_rdata == val_q) begin
					found_q <= CW'(idx_s1) + CW'(1);
				end
			end
		end
		idx_s1 <= ptr_q;
	end

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the sequential list engine: random and directed list requests.
`timescale 1ns / 1ps

module tb_top;
	import sle_pkg::*;

	localparam int unsigned LIST_CAP       = 64;
	localparam int unsigned RANDOM_ITEMS   = 550;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES   = 100;
	localparam int unsigned MAX_PRINTED    = 200;

	// Opcodes that the block does not define; they must be rejected.
	localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

	// One request transaction as the driver sends it.
	typedef struct {
		logic [OP_W-1:0]  opcode;
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] value;
	} list_req_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // position[6:0], value[38:7], zero fill
	logic [2:0]  s_tuser;   // opcode[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // read_value[31:0], found_position[38:32],
	                        // list_length[45:39], zero fill
	logic [1:0]  m_tuser;   // status[1:0]

	// Request stream and expected results.
	list_req_t   request_queue[$];
	result_t     pending_results[$];
	int unsigned n_total;
	int unsigned n_accepted;
	int unsigned err_count;
	int unsigned idle_cycles;

	// Shadow copy of the list used to predict results.
	logic [VAL_W-1:0] list_mem[LIST_CAP];
	int unsigned      list_len;

	// Length seen by the stimulus generator, used to aim positions.
	int unsigned gen_len;

	// Driver and receiver pacing.
	list_req_t   cur_req;
	int unsigned burst_left;
	int unsigned gap_left;
	logic [7:0]  stall_phase;
	result_t     exp_res;

	sequential_list_engine_top #(
		.CAPACITY(LIST_CAP)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Apply one request to the shadow list and return the result it must give.
	function automatic result_t apply_request(list_req_t req);
		result_t     res;
		int unsigned idx;
		res = '0;
		res.status = ST_OK;
		case (req.opcode)
		OP_READ: begin
			if (req.position == 0 || req.position > list_len)
				res.status = ST_BADPOS;
			else
				res.read_value = list_mem[req.position - 1];
		end
		OP_FIND: begin
			for (idx = 0; idx < list_len; idx++)
				if (list_mem[idx] == req.value)
					res.found_position = POS_W'(idx + 1);
			if (res.found_position == 0)
				res.status = ST_NOTFOUND;
		end
		OP_APPEND: begin
			if (list_len >= LIST_CAP) begin
				res.status = ST_FULL;
			end else begin
				list_mem[list_len] = req.value;
				list_len++;
			end
		end
		OP_INSERT: begin
			// A full list is rejected before the position is looked at.
			if (list_len >= LIST_CAP) begin
				res.status = ST_FULL;
			end else if (req.position == 0 || req.position > list_len + 1) begin
				res.status = ST_BADPOS;
			end else begin
				for (idx = list_len; idx >= req.position; idx--)
					list_mem[idx] = list_mem[idx - 1];
				list_mem[req.position - 1] = req.value;
				list_len++;
			end
		end
		OP_DELETE: begin
			if (req.position == 0 || req.position > list_len) begin
				res.status = ST_BADPOS;
			end else begin
				for (idx = req.position - 1; idx + 1 < list_len; idx++)
					list_mem[idx] = list_mem[idx + 1];
				list_len--;
			end
		end
		default: begin
			res.status = ST_BADPOS;
		end
		endcase
		res.list_length = POS_W'(list_len);
		return res;
	endfunction

	// Queue one request and track the length it leaves behind.
	task automatic add_req(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
		list_req_t req;
		req.opcode   = op;
		req.position = pos;
		req.value    = val;
		request_queue.push_back(req);
		if (op == OP_APPEND && gen_len < LIST_CAP)
			gen_len++;
		else if (op == OP_INSERT && gen_len < LIST_CAP && pos != 0 && pos <= gen_len + 1)
			gen_len++;
		else if (op == OP_DELETE && pos != 0 && pos <= gen_len)
			gen_len--;
	endtask

	// Log one mismatch; printing stops after a while but counting goes on.
	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		err_count++;
		if (err_count <= MAX_PRINTED)
			$display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
				want);
	endtask

	// Stimulus, reset and end of run.
	initial begin
		logic [VAL_W-1:0] val_pool[8];
		logic [OP_W-1:0]  op;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		int unsigned      n;
		int unsigned      r;
		int unsigned      t_app;
		int unsigned      t_ins;
		int unsigned      t_del;
		int unsigned      t_rd;
		int unsigned      dwell;
		bit               grow;

		arst_n     = 1'b0;
		list_len   = 0;
		gen_len    = 0;
		err_count  = 0;
		n_accepted = 0;

		// Directed part: empty-list rejections, value extremes, edge positions.
		add_req(OP_READ, 7'd1, 32'd0);
		add_req(OP_FIND, 7'd0, 32'd0);
		add_req(OP_DELETE, 7'd1, 32'd0);
		add_req(OP_INSERT, 7'd0, 32'd5);
		add_req(OP_INSERT, 7'd2, 32'd5);
		add_req(OP_INSERT, 7'd1, 32'h7FFF_FFFF);
		add_req(OP_APPEND, 7'd127, 32'h8000_0000);
		add_req(OP_APPEND, 7'd0, 32'hFFFF_FFFF);
		add_req(OP_INSERT, 7'd4, 32'd0);
		add_req(OP_INSERT, 7'd2, 32'hFFFF_FFFF);
		add_req(OP_FIND, 7'd0, 32'hFFFF_FFFF);
		add_req(OP_FIND, 7'd3, 32'd12345);
		add_req(OP_READ, 7'd0, 32'd0);
		add_req(OP_READ, 7'd5, 32'd0);
		add_req(OP_READ, 7'd6, 32'd0);
		add_req(OP_READ, 7'd127, 32'hFFFF_FFFF);
		add_req(OP_DELETE, 7'd1, 32'd0);
		add_req(OP_DELETE, 7'd4, 32'd0);
		add_req(OP_DELETE, 7'd2, 32'd0);
		add_req(OP_DELETE, 7'd0, 32'd0);
		add_req(OP_UNUSED_FIRST, 7'd1, 32'd7);
		add_req(OP_UNUSED_LAST, 7'd127, 32'hFFFF_FFFF);
		add_req(OP_READ, 7'd1, 32'd0);

		// A small pool of values makes repeated values and find hits common.
		val_pool[0] = 32'h8000_0000;
		val_pool[1] = 32'h7FFF_FFFF;
		for (n = 2; n < 8; n++)
			val_pool[n] = $urandom;

		// Random part: alternate growing toward full and shrinking toward empty.
		grow  = 1'b1;
		dwell = 0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			t_app = grow ? 35 : 5;
			t_ins = grow ? 65 : 10;
			t_del = grow ? 75 : 60;
			t_rd  = grow ? 85 : 78;
			r   = $urandom_range(0, 99);
			val = ($urandom_range(0, 3) != 0) ? val_pool[$urandom_range(0, 7)] : $urandom;
			pos = POS_W'($urandom_range(0, 127));
			if (r >= 95) begin
				op = OP_W'($urandom_range(0, 7));
			end else if (r < t_app) begin
				op = OP_APPEND;
			end else if (r < t_ins) begin
				op  = OP_INSERT;
				pos = POS_W'($urandom_range(1, gen_len + 1));
			end else if (r < t_del) begin
				op = OP_DELETE;
				if (gen_len > 0)
					pos = POS_W'($urandom_range(1, gen_len));
			end else if (r < t_rd) begin
				op = OP_READ;
				if (gen_len > 0)
					pos = POS_W'($urandom_range(1, gen_len));
			end else begin
				op = OP_FIND;
			end
			add_req(op, pos, val);
			// Stay at full for a few requests so full rejections get exercised.
			if (grow && gen_len == LIST_CAP) begin
				dwell++;
				if (dwell > 6) begin
					grow  = 1'b0;
					dwell = 0;
				end
			end
			if (!grow && gen_len == 0)
				grow = 1'b1;
		end
		n_total = request_queue.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (n_accepted < n_total)
			@(posedge clk);
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0 && pending_results.size() == 0)
			$display("sequential_list_engine_top verification clean");
		else
			$display("sequential_list_engine_top verification failed");
		$finish;
	end

	// Request driver: bursts of transactions separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tuser    <= '0;
			burst_left = $urandom_range(1, 16);
			gap_left   = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				pending_results.push_back(apply_request(cur_req));
				n_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					s_tvalid <= 1'b0;
					gap_left--;
				end else if (request_queue.size() > 0) begin
					cur_req = request_queue.pop_front();
					s_tdata  <= {1'b0, cur_req.value, cur_req.position};
					s_tuser  <= cur_req.opcode;
					s_tvalid <= 1'b1;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 16);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result receiver backpressure: free flow, light stalls, heavy stalls, square wave.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready    <= 1'b0;
			stall_phase <= '0;
		end else begin
			stall_phase <= stall_phase + 8'd1;
			case (stall_phase[7:6])
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= ($urandom_range(0, 3) != 0);
			2'd2: m_tready <= ($urandom_range(0, 4) == 0);
			default: m_tready <= stall_phase[2];
			endcase
		end
	end

	// Result monitor and watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with no request pending", m_tdata[31:0], 32'd0);
				end else begin
					exp_res = pending_results.pop_front();
					if (m_tuser != exp_res.status)
						report_mismatch("status", 32'(m_tuser), 32'(exp_res.status));
					if (m_tdata[31:0] != exp_res.read_value)
						report_mismatch("read_value", m_tdata[31:0], exp_res.read_value);
					if (m_tdata[38:32] != exp_res.found_position)
						report_mismatch("found_position", 32'(m_tdata[38:32]),
							32'(exp_res.found_position));
					if (m_tdata[45:39] != exp_res.list_length)
						report_mismatch("list_length", 32'(m_tdata[45:39]),
							32'(exp_res.list_length));
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("sequential_list_engine_top verification failed");
				$finish;
			end
		end else begin
			idle_cycles = 0;
		end
	end

endmodule

@@ files.f @@
rtl/core/sle_pkg.sv
rtl/core/sle_mem.sv
rtl/core/sle_ctrl.sv
rtl/core/sequential_list_engine_top.sv
tb/sv/tb_top.sv
